>>> design/sepblur_pkg.sv
// Shared constants and types for the separable tent blur unit.
package sepblur_pkg;

    localparam int MAX_RADIUS_DEF = 8;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_ROWS       = 4096;
    localparam int ROW_W          = 13;
    localparam int CH_N           = 4;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef enum logic [1:0] {
        REG_RADIUS_X,
        REG_RADIUS_Y,
        REG_FRAME_WIDTH,
        REG_FRAME_HEIGHT
    } cfg_reg_t;

    typedef logic [CH_N-1:0][7:0] pixel_t;

    typedef struct packed {
        logic clear;
        logic shift;
    } cell_ctl_t;

endpackage

>>> design/sepblur_div.sv
// Four-lane restoring divider, one quotient bit per cycle.
module sepblur_div
    import sepblur_pkg::*;
#(
    parameter int SUM_W = 15,
    parameter int NUM_W = 7
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [CH_N-1:0][SUM_W-1:0]     dividend,
    input  logic [NUM_W-1:0]               divisor,
    output logic                           done,
    output pixel_t                         quotient
);

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic                       busy_reg;
    logic                       done_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic [NUM_W-1:0]           dvs_reg;
    logic [CH_N-1:0][NUM_W-1:0] rem_reg;
    logic [CH_N-1:0][NUM_W-1:0] rem_next;
    logic [CH_N-1:0][SUM_W-1:0] q_reg;
    logic [CH_N-1:0][SUM_W-1:0] q_next;

    always_comb
    begin
        logic [NUM_W:0] trial;
        for (int c = 0; c < CH_N; c++)
        begin
            trial = {rem_reg[c], q_reg[c][SUM_W-1]};
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next[c] = NUM_W'(trial - {1'b0, dvs_reg});
                q_next[c]   = {q_reg[c][SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[c] = trial[NUM_W-1:0];
                q_next[c]   = {q_reg[c][SUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (cnt_reg == CNT_W'(SUM_W - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvs_reg <= divisor;
            rem_reg <= '0;
            q_reg   <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign done = done_reg;

    always_comb
    begin
        for (int c = 0; c < CH_N; c++)
        begin
            quotient[c] = q_reg[c][7:0];
        end
    end

endmodule

>>> design/sepblur_cell.sv
// One column cell: holds a vertical result and its weight, adds its share to a passing sum.
module sepblur_cell
    import sepblur_pkg::*;
#(
    parameter int SUM_W = 15,
    parameter int WW    = 4
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cell_ctl_t                  ctl,
    input  pixel_t                     pix_in,
    input  logic [WW-1:0]              wgt_in,
    input  logic [CH_N-1:0][SUM_W-1:0] psum_in,
    output pixel_t                     pix_out,
    output logic [WW-1:0]              wgt_out,
    output logic [CH_N-1:0][SUM_W-1:0] psum_out
);

    pixel_t                     pix_reg;
    logic [WW-1:0]              wgt_reg;
    logic [CH_N-1:0][SUM_W-1:0] psum_reg;
    logic [CH_N-1:0][SUM_W-1:0] psum_next;

    always_comb
    begin
        logic [WW+7:0] prod;
        for (int c = 0; c < CH_N; c++)
        begin
            prod         = (WW+8)'(wgt_reg) * (WW+8)'(pix_reg[c]);
            psum_next[c] = psum_in[c] + SUM_W'(prod);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wgt_reg <= '0;
            pix_reg <= '0;
        end
        else if (ctl.clear)
        begin
            wgt_reg <= '0;
        end
        else if (ctl.shift)
        begin
            wgt_reg <= wgt_in;
            pix_reg <= pix_in;
        end
    end

    always_ff @(posedge clk)
    begin
        psum_reg <= psum_next;
    end

    assign pix_out  = pix_reg;
    assign wgt_out  = wgt_reg;
    assign psum_out = psum_reg;

endmodule

>>> design/separable_tent_blur_argb_unit.sv
// Separable tent blur of an ARGB raster frame: controller, row store and column cell chain.
// Each accepted pixel that yields a result is worked in order: for each window column, one row
//   store read per window row and then a divide; then the sum ripples through the cell chain
//   and is divided once more. The first beat of a frame also latches the frame settings.
// The unit takes one item at a time and stalls its input until that item is done.
//   Reset: asynchronous, active low; counters and config to defaults.
module separable_tent_blur_argb_unit
    import sepblur_pkg::*;
#(
    parameter int MAX_RADIUS = MAX_RADIUS_DEF,
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pix_valid,
    output logic        pix_stall,
    input  logic        cmd,
    input  logic [7:0]  alpha,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    output logic        blur_valid,
    input  logic        blur_stall,
    output logic [7:0]  blur_alpha,
    output logic [7:0]  blur_red,
    output logic [7:0]  blur_green,
    output logic [7:0]  blur_blue,
    output logic        frame_done,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data
);

    localparam int NSLOT  = 2 * MAX_RADIUS + 2;
    localparam int NCELL  = 2 * MAX_RADIUS + 1;
    localparam int SLOT_W = $clog2(NSLOT);
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int XW     = $clog2(MAX_WIDTH + 1);
    localparam int RW     = $clog2(MAX_RADIUS + 1);
    localparam int WW     = $clog2(MAX_RADIUS + 2);
    localparam int KW     = $clog2(NCELL + 1);
    localparam int NUM_W  = $clog2((MAX_RADIUS + 1) * (MAX_RADIUS + 1) + 1);
    localparam int SUM_W  = $clog2((MAX_RADIUS + 1) * (MAX_RADIUS + 1) * 255 + 1);
    localparam int TOT_W  = XW + ROW_W;
    localparam int TICK_W = TOT_W + 1;
    localparam int ADDR_W = SLOT_W + COL_W;
    localparam int DEPTH  = NSLOT * (2 ** COL_W);
    localparam int EXT_W  = 15;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LATCH,
        S_MUL,
        S_WRITE,
        S_VADDR,
        S_VACC,
        S_VDIV,
        S_HSUM,
        S_HDIV,
        S_OUT
    } state_t;

    // Configuration registers
    logic [3:0]  radius_x_reg;
    logic [3:0]  radius_y_reg;
    logic [10:0] width_reg;
    logic [12:0] height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_x_reg <= 4'd1;
            radius_y_reg <= 4'd1;
            width_reg    <= 11'd1024;
            height_reg   <= 13'd768;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_RADIUS_X:     radius_x_reg <= cfg_data[3:0];
                REG_RADIUS_Y:     radius_y_reg <= cfg_data[3:0];
                REG_FRAME_WIDTH:  width_reg    <= cfg_data[10:0];
                REG_FRAME_HEIGHT: height_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Frame settings clamp, latched on the first beat of a frame
    logic [EXT_W-1:0] w_c, h_c, rx_c, ry_c;

    always_comb
    begin
        w_c = EXT_W'(width_reg);
        if (w_c == '0)
            w_c = EXT_W'(1);
        else if (w_c > EXT_W'(MAX_WIDTH))
            w_c = EXT_W'(MAX_WIDTH);
        h_c = EXT_W'(height_reg);
        if (h_c == '0)
            h_c = EXT_W'(1);
        else if (h_c > EXT_W'(MAX_ROWS))
            h_c = EXT_W'(MAX_ROWS);
        rx_c = EXT_W'(radius_x_reg);
        if (rx_c > EXT_W'(MAX_RADIUS))
            rx_c = EXT_W'(MAX_RADIUS);
        if (rx_c > w_c - 1'b1)
            rx_c = w_c - 1'b1;
        ry_c = EXT_W'(radius_y_reg);
        if (ry_c > EXT_W'(MAX_RADIUS))
            ry_c = EXT_W'(MAX_RADIUS);
        if (ry_c > h_c - 1'b1)
            ry_c = h_c - 1'b1;
    end

    // Control and datapath state
    state_t                     state_reg;
    logic                       cmd_reg;
    pixel_t                     pix_reg;
    logic [XW-1:0]              act_w_reg;
    logic [ROW_W-1:0]           act_h_reg;
    logic [RW-1:0]              act_rx_reg;
    logic [RW-1:0]              act_ry_reg;
    logic [TOT_W-1:0]           total_reg;
    logic [TOT_W-1:0]           delay_reg;
    logic [TICK_W-1:0]          tick_reg;
    logic [COL_W-1:0]           in_col_reg;
    logic [ROW_W-1:0]           in_row_reg;
    logic [SLOT_W-1:0]          in_slot_reg;
    logic [COL_W-1:0]           out_col_reg;
    logic [ROW_W-1:0]           out_row_reg;
    logic [SLOT_W-1:0]          out_slot_reg;
    logic [KW-1:0]              k_reg;
    logic [KW-1:0]              cnt_reg;
    logic [XW-1:0]              x_reg;
    logic [XW-1:0]              hi_reg;
    logic [CH_N-1:0][SUM_W-1:0] vsum_reg;
    logic [NUM_W-1:0]           vnum_reg;
    logic [NUM_W-1:0]           hnum_reg;
    logic                       tap_vld_reg;
    logic [WW-1:0]              tap_wgt_reg;
    logic                       div_start_reg;
    logic                       blur_valid_reg;
    pixel_t                     blur_reg;
    logic                       frame_done_reg;

    // Row store
    pixel_t                     mem [DEPTH];
    pixel_t                     rd_data_reg;
    logic [ADDR_W-1:0]          raddr;
    logic [ADDR_W-1:0]          waddr;
    logic                       wr_en;

    // Divider and cell chain
    logic                       div_done;
    pixel_t                     div_q;
    logic [CH_N-1:0][SUM_W-1:0] div_dividend;
    logic [NUM_W-1:0]           div_divisor;
    cell_ctl_t                  cell_ctl;
    pixel_t                     pix_w  [NCELL+1];
    logic [WW-1:0]              wgt_w  [NCELL+1];
    logic [CH_N-1:0][SUM_W-1:0] psum_w [NCELL+1];

    // Combinational helpers
    logic                       in_frame;
    logic                       need_out;
    logic [ROW_W:0]             y_off;
    logic [ROW_W:0]             ry_ext;
    logic                       tap_vld;
    logic [SLOT_W+1:0]          s_tmp;
    logic [SLOT_W-1:0]          tap_slot;
    logic [KW-1:0]              dk;
    logic [WW-1:0]              tap_wgt;
    logic [XW-1:0]              dx;
    logic [WW-1:0]              col_wgt;
    logic [XW-1:0]              lo_col;
    logic [XW:0]                hi_sum;
    logic [XW-1:0]              hi_col;
    logic                       last_out;
    logic                       out_free;

    assign in_frame = (tick_reg < TICK_W'(total_reg));
    assign need_out = (tick_reg >= TICK_W'(delay_reg));
    assign wr_en    = (state_reg == S_WRITE) && in_frame && (cmd_reg == CMD_PIXEL);
    assign waddr    = {in_slot_reg, in_col_reg};

    // Vertical tap: row out_row + k - ry
    assign ry_ext  = (ROW_W+1)'(act_ry_reg);
    assign y_off   = (ROW_W+1)'(out_row_reg) + (ROW_W+1)'(k_reg);
    assign tap_vld = (y_off >= ry_ext) && ((y_off - ry_ext) < (ROW_W+1)'(act_h_reg));

    always_comb
    begin
        s_tmp = (SLOT_W+2)'(out_slot_reg) + (SLOT_W+2)'(k_reg) + (SLOT_W+2)'(NSLOT)
              - (SLOT_W+2)'(act_ry_reg);
        if (s_tmp >= (SLOT_W+2)'(2 * NSLOT))
            s_tmp = s_tmp - (SLOT_W+2)'(2 * NSLOT);
        else if (s_tmp >= (SLOT_W+2)'(NSLOT))
            s_tmp = s_tmp - (SLOT_W+2)'(NSLOT);
        tap_slot = s_tmp[SLOT_W-1:0];
    end

    assign dk      = (k_reg >= KW'(act_ry_reg)) ? (k_reg - KW'(act_ry_reg))
                                                : (KW'(act_ry_reg) - k_reg);
    assign tap_wgt = WW'(act_ry_reg) - WW'(dk) + 1'b1;
    assign raddr   = {tap_slot, x_reg[COL_W-1:0]};

    // Horizontal weight of column x
    assign dx      = (x_reg >= XW'(out_col_reg)) ? (x_reg - XW'(out_col_reg))
                                                 : (XW'(out_col_reg) - x_reg);
    assign col_wgt = WW'(act_rx_reg) - WW'(dx) + 1'b1;

    // Clipped column window
    assign lo_col = (XW'(out_col_reg) > XW'(act_rx_reg)) ? XW'(out_col_reg) - XW'(act_rx_reg)
                                                         : '0;
    assign hi_sum = (XW+1)'(out_col_reg) + (XW+1)'(act_rx_reg);
    assign hi_col = (hi_sum > (XW+1)'(act_w_reg - 1'b1)) ? (act_w_reg - 1'b1) : XW'(hi_sum);

    assign last_out = (out_row_reg >= act_h_reg - 1'b1)
                   && (XW'(out_col_reg) >= act_w_reg - 1'b1);
    assign out_free = !blur_valid_reg || !blur_stall;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[waddr] <= pix_reg;
        end
        rd_data_reg <= mem[raddr];
    end

    // Cell chain: shift in one vertical result per column, then let the sum ripple out
    assign cell_ctl.clear = (state_reg == S_WRITE) && !(in_frame && cmd_reg == CMD_DRAIN)
                          && need_out;
    assign cell_ctl.shift = (state_reg == S_VDIV) && div_done;
    assign pix_w[0]  = div_q;
    assign wgt_w[0]  = col_wgt;
    assign psum_w[0] = '0;

    for (genvar i = 0; i < NCELL; i++)
    begin : g_cell
        sepblur_cell #(
            .SUM_W (SUM_W),
            .WW    (WW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (cell_ctl),
            .pix_in   (pix_w[i]),
            .wgt_in   (wgt_w[i]),
            .psum_in  (psum_w[i]),
            .pix_out  (pix_w[i+1]),
            .wgt_out  (wgt_w[i+1]),
            .psum_out (psum_w[i+1])
        );
    end

    assign div_dividend = (state_reg == S_HDIV) ? psum_w[NCELL] : vsum_reg;
    assign div_divisor  = (state_reg == S_HDIV) ? hnum_reg : vnum_reg;

    sepblur_div #(
        .SUM_W (SUM_W),
        .NUM_W (NUM_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            tick_reg       <= '0;
            in_col_reg     <= '0;
            in_row_reg     <= '0;
            in_slot_reg    <= '0;
            out_col_reg    <= '0;
            out_row_reg    <= '0;
            out_slot_reg   <= '0;
            div_start_reg  <= 1'b0;
            blur_valid_reg <= 1'b0;
            act_w_reg      <= XW'(MAX_WIDTH);
            act_h_reg      <= ROW_W'(768);
            act_rx_reg     <= RW'(1);
            act_ry_reg     <= RW'(1);
            total_reg      <= '0;
            delay_reg      <= '0;
        end
        else
        begin
            // Kick the divider after the last vertical tap and after the ripple
            div_start_reg <= ((state_reg == S_VACC) && (k_reg == KW'(2 * act_ry_reg)))
                          || ((state_reg == S_HSUM) && (cnt_reg == KW'(NCELL - 1)));
            // Drop the result beat once taken, unless a new one replaces it
            if (blur_valid_reg && !blur_stall && (state_reg != S_OUT))
            begin
                blur_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (pix_valid)
                    begin
                        cmd_reg   <= cmd;
                        pix_reg   <= {blue, green, red, alpha};
                        state_reg <= (tick_reg == '0) ? S_LATCH : S_WRITE;
                    end
                end

                S_LATCH:
                begin
                    act_w_reg  <= XW'(w_c);
                    act_h_reg  <= ROW_W'(h_c);
                    act_rx_reg <= RW'(rx_c);
                    act_ry_reg <= RW'(ry_c);
                    state_reg  <= S_MUL;
                end

                S_MUL:
                begin
                    total_reg <= TOT_W'(act_w_reg) * TOT_W'(act_h_reg);
                    delay_reg <= TOT_W'(act_ry_reg) * TOT_W'(act_w_reg) + TOT_W'(act_rx_reg);
                    state_reg <= S_WRITE;
                end

                S_WRITE:
                begin
                    if (in_frame && cmd_reg == CMD_DRAIN)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        if (wr_en)
                        begin
                            if (XW'(in_col_reg) + 1'b1 >= act_w_reg)
                            begin
                                in_col_reg  <= '0;
                                in_row_reg  <= in_row_reg + 1'b1;
                                in_slot_reg <= (in_slot_reg == SLOT_W'(NSLOT - 1))
                                             ? '0 : in_slot_reg + 1'b1;
                            end
                            else
                            begin
                                in_col_reg <= in_col_reg + 1'b1;
                            end
                        end
                        tick_reg <= tick_reg + 1'b1;
                        if (need_out)
                        begin
                            x_reg     <= lo_col;
                            hi_reg    <= hi_col;
                            hnum_reg  <= '0;
                            k_reg     <= '0;
                            vsum_reg  <= '0;
                            vnum_reg  <= '0;
                            state_reg <= S_VADDR;
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end

                S_VADDR:
                begin
                    tap_vld_reg <= tap_vld;
                    tap_wgt_reg <= tap_wgt;
                    state_reg   <= S_VACC;
                end

                S_VACC:
                begin
                    if (tap_vld_reg)
                    begin
                        for (int c = 0; c < CH_N; c++)
                        begin
                            vsum_reg[c] <= vsum_reg[c]
                                         + SUM_W'((WW+8)'(tap_wgt_reg) * (WW+8)'(rd_data_reg[c]));
                        end
                        vnum_reg <= vnum_reg + NUM_W'(tap_wgt_reg);
                    end
                    if (k_reg == KW'(2 * act_ry_reg))
                    begin
                        state_reg <= S_VDIV;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_VADDR;
                    end
                end

                S_VDIV:
                begin
                    if (div_done)
                    begin
                        hnum_reg <= hnum_reg + NUM_W'(col_wgt);
                        x_reg    <= x_reg + 1'b1;
                        if (x_reg == hi_reg)
                        begin
                            cnt_reg   <= '0;
                            state_reg <= S_HSUM;
                        end
                        else
                        begin
                            k_reg     <= '0;
                            vsum_reg  <= '0;
                            vnum_reg  <= '0;
                            state_reg <= S_VADDR;
                        end
                    end
                end

                S_HSUM:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == KW'(NCELL - 1))
                    begin
                        state_reg <= S_HDIV;
                    end
                end

                S_HDIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_OUT;
                    end
                end

                S_OUT:
                begin
                    if (out_free)
                    begin
                        blur_valid_reg <= 1'b1;
                        blur_reg       <= div_q;
                        frame_done_reg <= last_out;
                        if (last_out)
                        begin
                            tick_reg     <= '0;
                            in_col_reg   <= '0;
                            in_row_reg   <= '0;
                            in_slot_reg  <= '0;
                            out_col_reg  <= '0;
                            out_row_reg  <= '0;
                            out_slot_reg <= '0;
                        end
                        else if (XW'(out_col_reg) + 1'b1 >= act_w_reg)
                        begin
                            out_col_reg  <= '0;
                            out_row_reg  <= out_row_reg + 1'b1;
                            out_slot_reg <= (out_slot_reg == SLOT_W'(NSLOT - 1))
                                          ? '0 : out_slot_reg + 1'b1;
                        end
                        else
                        begin
                            out_col_reg <= out_col_reg + 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign pix_stall  = (state_reg != S_IDLE);
    assign blur_valid = blur_valid_reg;
    assign blur_alpha = blur_reg[0];
    assign blur_red   = blur_reg[1];
    assign blur_green = blur_reg[2];
    assign blur_blue  = blur_reg[3];
    assign frame_done = frame_done_reg;

    // The divider only finishes while the sequencer waits on it
    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_VDIV || state_reg == S_HDIV))
        else $error("divider finished outside a divide state");

    // A result beat is only raised from the output state
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(blur_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside the output state");

    // The horizontal divide never starts with an empty weight sum
    a_hnum_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (div_start_reg && state_reg == S_HDIV) |-> (hnum_reg != '0))
        else $error("horizontal divide with zero weight");

    // Ring slot pointers stay inside the row ring
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        (int'(in_slot_reg) < NSLOT) && (int'(out_slot_reg) < NSLOT))
        else $error("row ring slot out of range");

endmodule

>>> tb/sv/separable_tent_blur_argb_unit_test.sv
// Self-checking testbench for the separable tent blur unit: small frames, predicted blur.
module separable_tent_blur_argb_unit_test;
    import sepblur_pkg::*;

    localparam int RING_ROWS   = 2 * MAX_RADIUS_DEF + 2;
    localparam int QUIET_LIMIT = 20000;
    localparam int HOLD_CYCLES = 3000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        pix_valid = 1'b0;
    logic        pix_stall;
    logic        cmd = CMD_PIXEL;
    logic [7:0]  alpha = '0;
    logic [7:0]  red = '0;
    logic [7:0]  green = '0;
    logic [7:0]  blue = '0;
    logic        blur_valid;
    logic        blur_stall = 1'b0;
    logic [7:0]  blur_alpha;
    logic [7:0]  blur_red;
    logic [7:0]  blur_green;
    logic [7:0]  blur_blue;
    logic        frame_done;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [12:0] cfg_data = '0;

    int error_count = 0;
    int quiet_cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_request = 1'b0;

    // One blurred pixel as it should leave the block.
    typedef struct {
        pixel_t px;
        logic   done;
    } blur_beat_t;

    separable_tent_blur_argb_unit DUT (.*);

    always #4 clk = ~clk;

    // Print one mismatch line and count it.
    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // Mirror of the blur: register copies, frame counters and the ring of input rows.
    class blur_scoreboard;
        int unsigned reg_rx = 1, reg_ry = 1, reg_w = 1024, reg_h = 768;
        int unsigned w, h, rx, ry, delay;
        int unsigned in_col, in_row, out_col, out_row, tick;
        pixel_t      ring [RING_ROWS][MAX_WIDTH_DEF];
        blur_beat_t  pending[$];

        function void write_reg(cfg_reg_t idx, logic [12:0] data);
            case (idx)
                REG_RADIUS_X:     reg_rx = data[3:0];
                REG_RADIUS_Y:     reg_ry = data[3:0];
                REG_FRAME_WIDTH:  reg_w  = data[10:0];
                REG_FRAME_HEIGHT: reg_h  = data[12:0];
                default: ;
            endcase
        endfunction

        // Take the frame settings, clamped as the block clamps them.
        function void start_frame();
            w  = (reg_w < 1) ? 1 : (reg_w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : reg_w;
            h  = (reg_h < 1) ? 1 : (reg_h > MAX_ROWS) ? MAX_ROWS : reg_h;
            rx = (reg_rx > MAX_RADIUS_DEF) ? MAX_RADIUS_DEF : reg_rx;
            ry = (reg_ry > MAX_RADIUS_DEF) ? MAX_RADIUS_DEF : reg_ry;
            if (rx > w - 1) rx = w - 1;
            if (ry > h - 1) ry = h - 1;
            delay = ry * w + rx;
        endfunction

        function int unsigned column_tent(int unsigned r, int unsigned col, int ch);
            int unsigned lo, hi, acc, wsum, d;
            lo = (r > ry) ? r - ry : 0;
            hi = (r + ry > h - 1) ? h - 1 : r + ry;
            acc = 0;
            wsum = 0;
            for (int unsigned y = lo; y <= hi; y++)
            begin
                d = (y > r) ? y - r : r - y;
                acc += (ry - d + 1) * ring[y % RING_ROWS][col][ch];
                wsum += ry - d + 1;
            end
            return acc / wsum;
        endfunction

        function logic [7:0] tent_blur(int unsigned r, int unsigned c, int ch);
            int unsigned lo, hi, acc, wsum, d;
            lo = (c > rx) ? c - rx : 0;
            hi = (c + rx > w - 1) ? w - 1 : c + rx;
            acc = 0;
            wsum = 0;
            for (int unsigned x = lo; x <= hi; x++)
            begin
                d = (x > c) ? x - c : c - x;
                acc += (rx - d + 1) * column_tent(r, x, ch);
                wsum += rx - d + 1;
            end
            return 8'(acc / wsum);
        endfunction

        // Note an accepted input beat and queue the blurred pixel it releases, if any.
        function void note_input(logic op, pixel_t px);
            blur_beat_t b;
            if (tick == 0) start_frame();
            if (tick < w * h)
            begin
                if (op == CMD_DRAIN) return;
                ring[in_row % RING_ROWS][in_col] = px;
                in_col++;
                if (in_col >= w)
                begin
                    in_col = 0;
                    in_row++;
                end
            end
            tick++;
            if (tick - 1 < delay) return;
            for (int ch = 0; ch < CH_N; ch++)
                b.px[ch] = tent_blur(out_row, out_col, ch);
            b.done = (out_row >= h - 1 && out_col >= w - 1);
            pending.push_back(b);
            out_col++;
            if (out_col >= w)
            begin
                out_col = 0;
                out_row++;
            end
            if (b.done)
            begin
                in_col = 0;
                in_row = 0;
                out_col = 0;
                out_row = 0;
                tick = 0;
            end
        endfunction

        // Compare an accepted output beat with the oldest expected pixel.
        task check_result(pixel_t px, logic done);
            blur_beat_t b;
            if (pending.size() == 0)
            begin
                report_mismatch("output beat with nothing expected");
                return;
            end
            b = pending.pop_front();
            for (int ch = 0; ch < CH_N; ch++)
                if (px[ch] !== b.px[ch])
                    report_mismatch($sformatf("channel %0d got %0d expected %0d",
                                              ch, px[ch], b.px[ch]));
            if (done !== b.done)
                report_mismatch($sformatf("frame_done got %0b expected %0b", done, b.done));
        endtask
    endclass

    blur_scoreboard sb = new();

    // Output side: check accepted beats, then pick the stall for the next cycle.
    // A hold request keeps stall high for a long stretch so the block backs up.
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && blur_valid && !blur_stall)
                sb.check_result({blur_blue, blur_green, blur_red, blur_alpha}, frame_done);
            if (hold_request && hold_left == 0)
            begin
                hold_left = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                blur_stall <= 1'b1;
            end
            else
                blur_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog: count cycles in which no channel moves a beat.
    always @(posedge clk)
    begin
        if ((pix_valid && !pix_stall) || (blur_valid && !blur_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Offer one beat, with random idle cycles ahead of it; valid stays high afterward.
    task automatic send_beat(input logic op, input pixel_t px);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pix_valid <= 1'b0;
            @(posedge clk);
        end
        pix_valid <= 1'b1;
        cmd   <= op;
        alpha <= px[0];
        red   <= px[1];
        green <= px[2];
        blue  <= px[3];
        @(posedge clk);
        while (pix_stall) @(posedge clk);
        sb.note_input(op, px);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [12:0] data);
        pix_valid <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    // Drop valid, wait for every expected pixel, then give trailing work time to settle.
    task automatic wait_idle();
        pix_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    // Program a frame, then feed its pixels with stray drains mixed in, then the
    // flush ticks (mostly drains, some surplus pixels whose bytes are dropped).
    task automatic run_frame(input logic [12:0] rxv, input logic [12:0] ryv,
                             input logic [12:0] wv, input logic [12:0] hv, input bit extremes);
        pixel_t px;
        int unsigned npix, flush;
        wait_idle();
        write_reg(REG_RADIUS_X, rxv);
        write_reg(REG_RADIUS_Y, ryv);
        write_reg(REG_FRAME_WIDTH, wv);
        write_reg(REG_FRAME_HEIGHT, hv);
        sb.start_frame();
        npix = sb.w * sb.h;
        flush = sb.delay;
        for (int unsigned i = 0; i < npix; i++)
        begin
            if ($urandom_range(99) < 8)
                send_beat(CMD_DRAIN, pixel_t'($urandom));
            if (extremes)
                px = (i % 2) ? {8'hFF, 8'h00, 8'hFF, 8'h00} : {8'h00, 8'hFF, 8'h00, 8'hFF};
            else
                px = pixel_t'($urandom);
            send_beat(CMD_PIXEL, px);
        end
        for (int unsigned i = 0; i < flush; i++)
            send_beat(($urandom_range(99) < 20) ? CMD_PIXEL : CMD_DRAIN, pixel_t'($urandom));
    endtask

    initial
    begin
        int frames;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: single pixel, clamped radii, zero sizes, tall and wide strips.
        run_frame(13'd0, 13'd0, 13'd1, 13'd1, 1'b1);
        run_frame(13'h1FF8, 13'h0AA8, 13'd5, 13'd4, 1'b1);
        run_frame(13'd15, 13'd15, 13'd3, 13'd3, 1'b0);
        run_frame(13'd2, 13'd1, 13'd0, 13'd0, 1'b1);
        run_frame(13'd3, 13'd0, 13'd40, 13'd1, 1'b0);
        run_frame(13'd1, 13'd3, 13'd1, 13'd40, 1'b0);

        // Random frames; idling pattern rotates every few frames.
        frames = 0;
        while (frames < 12)
        begin
            case ((frames / 3) % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            if (frames == 3) hold_request = 1'b1;
            run_frame({9'($urandom_range(511)), 4'($urandom_range(15))},
                      {9'($urandom_range(511)), 4'($urandom_range(15))},
                      13'($urandom_range(7, 1)), 13'($urandom_range(6, 1)), 1'b0);
            frames++;
        end

        wait_idle();
        repeat (200) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> separable_tent_blur_argb_unit.f
design/sepblur_pkg.sv
design/sepblur_div.sv
design/sepblur_cell.sv
design/separable_tent_blur_argb_unit.sv
tb/sv/separable_tent_blur_argb_unit_test.sv
